### hw/rtl/rsf_pkg.sv
package rsf_pkg;

  localparam int MaxWidth  = 2048;
  localparam int MaxHeight = 2048;
  localparam int DimW      = 12;
  localparam int PosW      = $clog2(MaxWidth);
  localparam int ChanW     = 8;
  localparam int PixW      = 3 * ChanW;
  localparam int SumW      = ChanW + 2;

  // configuration register indexes
  localparam logic [1:0] CfgImageWidth  = 2'd0;
  localparam logic [1:0] CfgImageHeight = 2'd1;
  localparam logic [1:0] CfgBandFirst   = 2'd2;
  localparam logic [1:0] CfgBandEnd     = 2'd3;

  // blue in the low byte, then green, then red
  typedef logic [PixW-1:0] pixel_t;
  // entry 0 is the oldest row of the column, entry 2 the newest
  typedef logic [2:0][PixW-1:0] col_t;
  typedef logic [2:0][SumW-1:0] csum_t;

  typedef struct packed {
    logic            emit;
    logic [PosW-1:0] row;
    logic [PosW-1:0] col;
    logic            last;
  } pos_t;

  function automatic csum_t col_sum(col_t c);
    csum_t s;
    for (int k = 0; k < 3; k++) begin
      s[k] = SumW'(c[0][ChanW*k +: ChanW]) + SumW'(c[1][ChanW*k +: ChanW])
           + SumW'(c[2][ChanW*k +: ChanW]);
    end
    return s;
  endfunction

endpackage

### hw/rtl/rsf_line_buf.sv
module rsf_line_buf (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic [rsf_pkg::PosW-1:0] addr_i,
  input  logic                    wr_slot_i,
  input  rsf_pkg::pixel_t         wr_data_i,
  output rsf_pkg::pixel_t         rd0_o,
  output rsf_pkg::pixel_t         rd1_o
);
  import rsf_pkg::*;

  pixel_t mem0 [MaxWidth];
  pixel_t mem1 [MaxWidth];
  pixel_t rd0_q, rd1_q;

  // read returns the word stored before this cycle's write
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rd0_q <= mem0[addr_i];
      rd1_q <= mem1[addr_i];
      if (wr_slot_i) begin
        mem1[addr_i] <= wr_data_i;
      end else begin
        mem0[addr_i] <= wr_data_i;
      end
    end
  end

  assign rd0_o = rd0_q;
  assign rd1_o = rd1_q;

endmodule

### hw/rtl/rsf_col_cell.sv
module rsf_col_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           shift_i,
  input  rsf_pkg::col_t  col_i,
  output rsf_pkg::col_t  col_o,
  output rsf_pkg::csum_t sum_o
);
  import rsf_pkg::*;

  col_t col_q;
  csum_t sum_q;

  // column sum is kept alongside the pixels so the kernel stage adds fewer terms
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      sum_q <= '0;
    end else if (shift_i) begin
      col_q <= col_i;
      sum_q <= col_sum(col_i);
    end
  end

  assign col_o = col_q;
  assign sum_o = sum_q;

endmodule

### hw/rtl/rgb_sharpen_3x3_filter.sv
// the result centered on pixel (r-1, c-1) is shown after pixel (r, c) passes the window
//   stage and the output register; border pixels and rows outside the band give no word
// throughput: one pixel per cycle while m_axis_tready is high, set by one read of both
//   line slots and one write per cycle into the line buffer
// reset: counters, window cells and output valid are cleared, registers take defaults;
//   the line buffer is not cleared and needs no clearing pass
module rgb_sharpen_3x3_filter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [11:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // in_blue, in_green, in_red
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // out_blue, out_green, out_red, out_row, out_col, zero pad
  output logic        m_axis_tlast    // band_last
);
  import rsf_pkg::*;

  logic [DimW-1:0] width_q, height_q, first_q, end_q;
  logic [PosW-1:0] c_q, c_d, r_q, r_d;
  logic            en, accept, wrap;
  logic [DimW-1:0] w_s, h_s, first_s, hm1_s, endr_s, i_ext, c_ext;
  logic [PosW-1:0] i_s, j_s;
  pos_t            pos_d, pos1_q;
  logic            v1_q, par1_q, shift;
  pixel_t          px1_q, rd0, rd1;
  col_t            cur, col_a, col_b;
  csum_t           sum_a, sum_b, sum_c;
  logic [2:0][DimW-1:0] sum9, ten_c;
  logic [2:0][DimW:0]   diff;
  pixel_t          res_d, res_q;
  logic            m_valid_q, m_last_q;
  logic [PosW-1:0] m_row_q, m_col_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 12'd640;
      height_q <= 12'd480;
      first_q  <= 12'd1;
      end_q    <= 12'd479;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgImageWidth:  width_q  <= cfg_data_i;
        CfgImageHeight: height_q <= cfg_data_i;
        CfgBandFirst:   first_q  <= cfg_data_i;
        CfgBandEnd:     end_q    <= cfg_data_i;
        default:        width_q  <= width_q;
      endcase
    end
  end

  // clamped geometry and band
  always_comb begin
    w_s     = (width_q > DimW'(MaxWidth)) ? DimW'(MaxWidth) : width_q;
    h_s     = (height_q > DimW'(MaxHeight)) ? DimW'(MaxHeight) : height_q;
    first_s = (first_q == '0) ? DimW'(1) : first_q;
    hm1_s   = h_s - DimW'(1);
    endr_s  = (end_q < hm1_s) ? end_q : hm1_s;
  end

  assign en            = !m_valid_q || m_axis_tready;
  assign s_axis_tready = en;
  assign accept        = s_axis_tvalid && en;

  // position of the pixel entering now and the window center it completes
  always_comb begin
    c_ext = {1'b0, c_q};
    i_s   = r_q - PosW'(1);
    j_s   = c_q - PosW'(1);
    i_ext = {1'b0, i_s};
    pos_d.emit = (r_q >= PosW'(2)) && (c_q >= PosW'(2)) && (c_ext < w_s)
              && ({1'b0, r_q} < h_s) && (i_ext >= first_s) && (i_ext < endr_s);
    pos_d.row  = i_s;
    pos_d.col  = j_s;
    pos_d.last = (i_ext == endr_s - DimW'(1)) && (c_ext + DimW'(1) == w_s);
    wrap = (c_ext + DimW'(1) >= w_s);
    c_d  = c_q;
    r_d  = r_q;
    if (wrap) begin
      c_d = '0;
      r_d = ({1'b0, r_q} + DimW'(1) >= h_s) ? '0 : r_q + PosW'(1);
    end else begin
      c_d = c_q + PosW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_q <= '0;
      r_q <= '0;
    end else if (accept) begin
      c_q <= c_d;
      r_q <= r_d;
    end
  end

  rsf_line_buf u_line_buf (
    .clk_i     (clk_i),
    .en_i      (accept),
    .addr_i    (c_q),
    .wr_slot_i (r_q[0]),
    .wr_data_i (s_axis_tdata),
    .rd0_o     (rd0),
    .rd1_o     (rd1)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pos1_q <= pos_d;
      px1_q  <= s_axis_tdata;
      par1_q <= r_q[0];
    end
  end

  // slot of the current row parity holds two rows back
  assign cur[0] = par1_q ? rd1 : rd0;
  assign cur[1] = par1_q ? rd0 : rd1;
  assign cur[2] = px1_q;
  assign shift  = v1_q && en;
  assign sum_c  = col_sum(cur);

  rsf_col_cell u_cell_a (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .shift_i (shift),
    .col_i   (cur),
    .col_o   (col_a),
    .sum_o   (sum_a)
  );

  rsf_col_cell u_cell_b (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .shift_i (shift),
    .col_i   (col_a),
    .col_o   (col_b),
    .sum_o   (sum_b)
  );

  // 10 * center minus the nine-pixel sum, then clamp to a byte
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sum9[k]  = DimW'(sum_a[k]) + DimW'(sum_b[k]) + DimW'(sum_c[k]);
      ten_c[k] = (DimW'(col_a[1][ChanW*k +: ChanW]) << 3)
               + (DimW'(col_a[1][ChanW*k +: ChanW]) << 1);
      diff[k]  = {1'b0, ten_c[k]} - {1'b0, sum9[k]};
      if (diff[k][DimW]) begin
        res_d[ChanW*k +: ChanW] = '0;
      end else if (diff[k][DimW-1:ChanW] != '0) begin
        res_d[ChanW*k +: ChanW] = '1;
      end else begin
        res_d[ChanW*k +: ChanW] = diff[k][ChanW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (en) begin
      m_valid_q <= v1_q && pos1_q.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_q    <= res_d;
      m_row_q  <= pos1_q.row;
      m_col_q  <= pos1_q.col;
      m_last_q <= pos1_q.last;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {2'b00, m_col_q, m_row_q, res_q};
  assign m_axis_tlast  = m_last_q;

  a_col_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !wrap |=> c_q == $past(c_q) + PosW'(1))
    else $error("column counter skipped");

  a_interior: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_row_q != '0 && m_col_q != '0)
    else $error("border pixel produced a word");

  a_last_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> {1'b0, m_col_q} + DimW'(2) == w_s)
    else $error("band end marked away from last interior column");

  a_stage_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q && !en |=> v1_q && $stable(pos1_q) && $stable(px1_q))
    else $error("window stage lost a word under stall");

endmodule

### sim/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import rsf_pkg::*;

  localparam int DrainCycles  = 8;
  localparam int StallLimit   = 3000;
  localparam int LongHold     = 400;
  localparam int RandomPixels = 1250;
  localparam int PrintLimit   = 100;

  typedef struct {
    logic [ChanW-1:0] blue;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] red;
    logic [PosW-1:0]  row;
    logic [PosW-1:0]  col;
    logic             band_last;
  } sharp_word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [11:0] cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic        m_axis_tlast;

  // predictor copy of the line buffer, window, counters and registers
  pixel_t          line_mem [2*MaxWidth];
  pixel_t          win_cols [6];
  int unsigned     col_cnt;
  int unsigned     row_cnt;
  logic [DimW-1:0] reg_width;
  logic [DimW-1:0] reg_height;
  logic [DimW-1:0] reg_band_lo;
  logic [DimW-1:0] reg_band_hi;

  sharp_word_t sharpened_q [$];
  int          mismatch_count = 0;
  int          pixels_sent = 0;
  int          stall_cycles = 0;
  int          rx_hold_cycles = 0;
  bit          tx_idle_on = 1'b1;
  bit          rx_idle_on = 1'b1;

  rgb_sharpen_3x3_filter DUT (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic void reset_predictor();
    foreach (line_mem[a]) line_mem[a] = '0;
    foreach (win_cols[a]) win_cols[a] = '0;
    col_cnt     = 0;
    row_cnt     = 0;
    reg_width   = 12'd640;
    reg_height  = 12'd480;
    reg_band_lo = 12'd1;
    reg_band_hi = 12'd479;
  endfunction

  // advance the window by one pixel and queue the sharpened word it completes
  function automatic void sharpen_pixel(pixel_t px);
    int unsigned w, h, c, r, ci, slot_old, slot_mid;
    int          lo, hi, i, j, s, k, t;
    pixel_t      cur [3];
    sharp_word_t word;
    logic [ChanW-1:0] val [3];
    w  = (reg_width > MaxWidth) ? MaxWidth : reg_width;
    h  = (reg_height > MaxHeight) ? MaxHeight : reg_height;
    c  = col_cnt;
    r  = row_cnt;
    ci = c % MaxWidth;
    slot_old = (r & 1) * MaxWidth;
    slot_mid = ((r + 1) & 1) * MaxWidth;
    lo = (reg_band_lo < 1) ? 1 : int'(reg_band_lo);
    hi = int'(h) - 1;
    if (int'(reg_band_hi) < hi) hi = int'(reg_band_hi);
    cur[0] = line_mem[slot_old + ci];
    cur[1] = line_mem[slot_mid + ci];
    cur[2] = px;
    if (r >= 2 && c >= 2 && c < w && r < h) begin
      i = int'(r) - 1;
      j = int'(c) - 1;
      if (i >= lo && i < hi) begin
        for (k = 0; k < 3; k++) begin
          // center weight 9 = 10 minus the center counted among the nine
          s = 10 * int'(win_cols[4][ChanW*k +: ChanW]);
          for (t = 0; t < 3; t++) begin
            s = s - int'(win_cols[t][ChanW*k +: ChanW])
                  - int'(win_cols[3+t][ChanW*k +: ChanW])
                  - int'(cur[t][ChanW*k +: ChanW]);
          end
          if (s < 0) val[k] = 8'd0;
          else if (s > 255) val[k] = 8'd255;
          else val[k] = ChanW'(s);
        end
        word.blue      = val[0];
        word.green     = val[1];
        word.red       = val[2];
        word.row       = PosW'(i);
        word.col       = PosW'(j);
        word.band_last = (i == hi - 1) && (j + 2 == int'(w));
        sharpened_q.push_back(word);
      end
    end
    line_mem[slot_old + ci] = px;
    for (k = 0; k < 3; k++) begin
      win_cols[k]   = win_cols[3+k];
      win_cols[3+k] = cur[k];
    end
    if (c + 1 >= w) begin
      col_cnt = 0;
      row_cnt = (r + 1 >= h) ? 0 : r + 1;
    end else begin
      col_cnt = c + 1;
    end
  endfunction

  function automatic pixel_t random_pixel();
    pixel_t     px;
    logic [7:0] base;
    int         k;
    case ($urandom_range(0, 3))
      0: px = pixel_t'($urandom);
      1: begin
        for (k = 0; k < 3; k++) px[ChanW*k +: ChanW] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      end
      // near-flat area, sums mostly stay inside the byte range
      2: begin
        base = $urandom_range(96, 160);
        px = {base + 8'($urandom_range(0, 15)), base, base - 8'($urandom_range(0, 15))};
      end
      default: px = $urandom_range(0, 1) ? '1 : '0;
    endcase
    return px;
  endfunction

  task automatic flag_mismatch(string field, int got, int want_v, int row, int col);
    if (mismatch_count < PrintLimit)
      $display("mismatch in %s at row %0d col %0d: got %0d, expected %0d",
               field, row, col, got, want_v);
    mismatch_count++;
  endtask

  task automatic send_pixel(pixel_t px);
    if (tx_idle_on && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= px;
    @(posedge clk_i);
    while (s_axis_tready !== 1'b1) @(posedge clk_i);
    sharpen_pixel(px);
    pixels_sent++;
  endtask

  // pixels until the counters wrap back to the frame origin
  task automatic send_frame();
    do send_pixel(random_pixel());
    while (col_cnt != 0 || row_cnt != 0);
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sharpened_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [DimW-1:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    case (idx)
      CfgImageWidth:  reg_width   = value;
      CfgImageHeight: reg_height  = value;
      CfgBandFirst:   reg_band_lo = value;
      CfgBandEnd:     reg_band_hi = value;
      default: ;
    endcase
  endtask

  task automatic set_geometry(logic [DimW-1:0] w, logic [DimW-1:0] h,
                              logic [DimW-1:0] lo, logic [DimW-1:0] hi);
    settle();
    write_reg(CfgImageWidth, w);
    write_reg(CfgImageHeight, h);
    write_reg(CfgBandFirst, lo);
    write_reg(CfgBandEnd, hi);
    cfg_we_i <= 1'b0;
  endtask

  task automatic test_directed_frames();
    int         r, c;
    logic [7:0] chk;
    // checkerboard drives both clamp limits, flat green stays mid range
    set_geometry(12'd4, 12'd4, 12'd0, 12'hFFF);
    for (r = 0; r < 4; r++) begin
      for (c = 0; c < 4; c++) begin
        chk = ((r + c) % 2 != 0) ? 8'hFF : 8'h00;
        send_pixel({~chk, 8'd128, chk});
      end
    end
    // smallest frame, single interior pixel
    set_geometry(12'd3, 12'd3, 12'd1, 12'd2);
    send_frame();
  endtask

  task automatic test_band_limits();
    logic [DimW-1:0] lo_set [6] = '{12'd2, 12'd0, 12'd3, 12'd2048, 12'd0, 12'd4};
    logic [DimW-1:0] hi_set [6] = '{12'd3, 12'd2, 12'd3, 12'hFFF, 12'hFFF, 12'd1};
    int              n;
    for (n = 0; n < 6; n++) begin
      set_geometry(12'd5, 12'd5, lo_set[n], hi_set[n]);
      send_frame();
    end
  endtask

  task automatic test_degenerate_geometry();
    set_geometry(12'd2, 12'd4, 12'd0, 12'hFFF);
    repeat (2) send_frame();
    set_geometry(12'd5, 12'd2, 12'd0, 12'hFFF);
    repeat (2) send_frame();
  endtask

  task automatic test_midframe_config();
    set_geometry(12'd8, 12'd6, 12'd0, 12'hFFF);
    repeat (22) send_pixel(random_pixel());
    settle();
    write_reg(CfgBandFirst, 12'd2);
    cfg_we_i <= 1'b0;
    // stop at row 4 column 7, past the narrower width written next
    repeat (17) send_pixel(random_pixel());
    settle();
    write_reg(CfgImageWidth, 12'd5);
    cfg_we_i <= 1'b0;
    repeat (3) send_pixel(random_pixel());
    // row 5 is beyond the new height and wraps at its end
    settle();
    write_reg(CfgImageHeight, 12'd4);
    cfg_we_i <= 1'b0;
    send_frame();
    send_frame();
  endtask

  task automatic test_saturated_geometry();
    // oversized width and height clamp to the maximum, band end clamps to height-1;
    // the smaller sizes written later pull the counters back
    set_geometry(12'hFFF, 12'hFFF, 12'd0, 12'hFFF);
    repeat (7) send_pixel(random_pixel());
    settle();
    write_reg(CfgImageWidth, 12'd5);
    cfg_we_i <= 1'b0;
    repeat (31) send_pixel(random_pixel());
    settle();
    write_reg(CfgImageHeight, 12'd5);
    cfg_we_i <= 1'b0;
    send_frame();
    send_frame();
  endtask

  task automatic test_output_backpressure();
    set_geometry(12'd16, 12'd8, 12'd0, 12'hFFF);
    tx_idle_on     = 1'b0;
    rx_hold_cycles = LongHold;
    repeat (2) send_frame();
    tx_idle_on = 1'b1;
  endtask

  task automatic test_random_frames();
    int start, w, h, lo, hi;
    start = pixels_sent;
    while (pixels_sent - start < RandomPixels) begin
      if (pixels_sent - start > RandomPixels - 400) begin
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
      end else begin
        tx_idle_on = ($urandom_range(0, 3) != 0);
        rx_idle_on = ($urandom_range(0, 3) != 0);
      end
      if ($urandom_range(0, 7) == 0) begin
        w = $urandom_range(40, 120);
        h = $urandom_range(3, 4);
      end else begin
        w = $urandom_range(3, 24);
        h = $urandom_range(3, 12);
      end
      lo = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, h - 2);
      hi = ($urandom_range(0, 5) == 0) ? 4095 : $urandom_range(lo, h + 1);
      set_geometry(w, h, lo, hi);
      repeat ($urandom_range(1, 2)) send_frame();
    end
  endtask

  initial begin : ready_driver
    int burst;
    @(posedge clk_i);
    forever begin
      if (rx_hold_cycles != 0) begin
        burst          = rx_hold_cycles;
        rx_hold_cycles = 0;
        m_axis_tready <= 1'b0;
        repeat (burst) @(posedge clk_i);
      end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  // tdata: blue [7:0], green [15:8], red [23:16], row [34:24], col [45:35], pad [47:46]
  always @(posedge clk_i) begin : check_words
    sharp_word_t want;
    if (m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) begin
      if (sharpened_q.size() == 0) begin
        flag_mismatch("unpredicted word", 1, 0, m_axis_tdata[34:24], m_axis_tdata[45:35]);
      end else begin
        want = sharpened_q.pop_front();
        if (m_axis_tdata[7:0] !== want.blue)
          flag_mismatch("blue", m_axis_tdata[7:0], want.blue, want.row, want.col);
        if (m_axis_tdata[15:8] !== want.green)
          flag_mismatch("green", m_axis_tdata[15:8], want.green, want.row, want.col);
        if (m_axis_tdata[23:16] !== want.red)
          flag_mismatch("red", m_axis_tdata[23:16], want.red, want.row, want.col);
        if (m_axis_tdata[34:24] !== want.row)
          flag_mismatch("row", m_axis_tdata[34:24], want.row, want.row, want.col);
        if (m_axis_tdata[45:35] !== want.col)
          flag_mismatch("col", m_axis_tdata[45:35], want.col, want.row, want.col);
        if (m_axis_tdata[47:46] !== 2'b00)
          flag_mismatch("pad", m_axis_tdata[47:46], 0, want.row, want.col);
        if (m_axis_tlast !== want.band_last)
          flag_mismatch("band_last", m_axis_tlast, want.band_last, want.row, want.col);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("rgb_sharpen_3x3_filter test failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    reset_predictor();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_frames();
    test_band_limits();
    test_degenerate_geometry();
    test_midframe_config();
    test_saturated_geometry();
    test_output_backpressure();
    test_random_frames();
    settle();
    if (mismatch_count == 0) begin
      $display("rgb_sharpen_3x3_filter test passed");
    end else begin
      $display("rgb_sharpen_3x3_filter test failed");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/rsf_pkg.sv
hw/rtl/rsf_line_buf.sv
hw/rtl/rsf_col_cell.sv
hw/rtl/rgb_sharpen_3x3_filter.sv
sim/testbench.sv
